@@ rtl/core/bmf_pkg.sv @@
package bmf_pkg;

  // Fixed field widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  // Register limits and reset values
  localparam int ROWS_MAX         = 4092;
  localparam int PADDED_WIDTH_RST = 2048;
  localparam int CONTENT_ROWS_RST = 1024;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PADDED_WIDTH = 1'b0,
    REG_CONTENT_ROWS = 1'b1
  } cfg_reg_t;

  // Control tag that travels with each request through the pipeline
  typedef struct packed {
    logic valid;
    logic produce;
    logic last;
  } tag_t;

endpackage

@@ rtl/core/bmf_ifs.sv @@
interface bmf_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bmf_mean_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::PIX_W-1:0]  mean_out;
  logic                       frame_last;

  modport source (output valid, output mean_out, output frame_last, input ready);
  modport sink   (input valid, input mean_out, input frame_last, output ready);
endinterface

interface bmf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bmf_pkg::CFG_IDX_W-1:0] index;
  logic [bmf_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/bmf_ram.sv @@
module bmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/bmf_window.sv @@
module bmf_window #(
  parameter int RADIUS = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic [$clog2((2*RADIUS+1)*255+1)-1:0] in_colsum,
  input  bmf_pkg::tag_t                         in_tag,
  output logic [bmf_pkg::PIX_W-1:0]             out_mean,
  output bmf_pkg::tag_t                         out_tag
);

  localparam int WIN     = 2 * RADIUS + 1;
  localparam int CS_W    = $clog2(WIN * 255 + 1);
  localparam int DIV     = WIN * WIN;
  localparam int SUM_W   = $clog2(DIV * 255 + 1);
  localparam int SHIFT   = SUM_W + $clog2(DIV);
  localparam int RECIP   = ((1 << SHIFT) + DIV - 1) / DIV;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = SUM_W + RECIP_W;

  logic [CS_W-1:0]   cs_q;
  logic [CS_W-1:0]   cols [WIN];
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  sum_next;
  logic [PROD_W-1:0] prod_q;
  bmf_pkg::tag_t     tag_a;
  bmf_pkg::tag_t     tag_b;
  bmf_pkg::tag_t     tag_c;

  // Window sum: newest column sum plus the older columns that stay
  always_comb begin
    sum_next = SUM_W'(cs_q);
    for (int k = 1; k < WIN; k++) begin
      sum_next = sum_next + SUM_W'(cols[k]);
    end
  end

  // Tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
      tag_b <= '0;
      tag_c <= '0;
    end else if (en) begin
      tag_a <= in_tag;
      tag_b <= tag_a;
      tag_c <= tag_b;
    end
  end

  // Column sums, window sum and reciprocal product
  always_ff @(posedge clk) begin
    if (en) begin
      cs_q <= in_colsum;
      if (tag_a.valid) begin
        for (int k = 0; k < WIN - 1; k++) begin
          cols[k] <= cols[k+1];
        end
        cols[WIN-1] <= cs_q;
      end
      sum_q  <= sum_next;
      prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
    end
  end

  assign out_mean = bmf_pkg::PIX_W'(prod_q >> SHIFT);
  assign out_tag  = tag_c;

endmodule

@@ rtl/core/box_mean_filter_5x5.sv @@
// Results pass the first stage, window and output registers. Throughput: one
// pixel per cycle when not stalled, set by the single read-modify-write per
// pixel on the line store RAM (read at acceptance, written back from stage
// one). Reset clears the counters, the pipeline valid bits and the registers
// to 2048 columns and 1024 rows; the line stores are not cleared.
module box_mean_filter_5x5 #(
  parameter int MAX_WIDTH = 2048,
  parameter int RADIUS    = 2
) (
  input  logic            clk,
  input  logic            rst,
  bmf_cfg_if.sink         cfg,
  bmf_pixel_if.sink       pixels,
  bmf_mean_if.source      means
);

  localparam int WIN       = 2 * RADIUS + 1;
  localparam int LINES     = 2 * RADIUS;
  localparam int PIX_W     = bmf_pkg::PIX_W;
  localparam int CFG_W     = bmf_pkg::CFG_W;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int EXT_W     = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int H_W       = $clog2(bmf_pkg::ROWS_MAX + LINES + 1);
  localparam int CS_W      = $clog2(WIN * 255 + 1);
  localparam int WORD_W    = PIX_W * LINES;
  localparam int WIDTH_RST = (bmf_pkg::PADDED_WIDTH_RST > MAX_WIDTH) ?
                             MAX_WIDTH : bmf_pkg::PADDED_WIDTH_RST;

  logic [EXT_W-1:0]  eff_width;
  logic [H_W-1:0]    eff_rows;
  logic [EXT_W-1:0]  width_next;
  logic [H_W-1:0]    rows_next;
  logic [COL_W-1:0]  col_cnt;
  logic [H_W-1:0]    row_cnt;
  logic              en;
  logic              accept;
  logic              row_end;
  logic              frame_end;
  logic              produce;
  bmf_pkg::tag_t     tag1;
  logic [PIX_W-1:0]  px1;
  logic [COL_W-1:0]  col1;
  logic              ram_wr;
  logic [WORD_W-1:0] ram_rd;
  logic [CS_W-1:0]   colsum;
  logic [PIX_W-1:0]  w_mean;
  bmf_pkg::tag_t     w_tag;
  logic              out_valid;
  logic [PIX_W-1:0]  mean_q;
  logic              last_q;

  // Stall everything while a result waits at the output
  assign en           = !out_valid || means.ready;
  assign pixels.ready = en;
  assign accept       = pixels.valid && en;
  assign cfg.ready    = 1'b1;

  // Saturate written register values
  always_comb begin
    width_next = EXT_W'(cfg.data);
    if (width_next < EXT_W'(WIN)) begin
      width_next = EXT_W'(WIN);
    end else if (width_next > EXT_W'(MAX_WIDTH)) begin
      width_next = EXT_W'(MAX_WIDTH);
    end
    rows_next = H_W'(cfg.data);
    if (rows_next < H_W'(1)) begin
      rows_next = H_W'(1);
    end else if (rows_next > H_W'(bmf_pkg::ROWS_MAX)) begin
      rows_next = H_W'(bmf_pkg::ROWS_MAX);
    end
    rows_next = rows_next + H_W'(LINES);
  end

  // Hold effective width and total frame rows
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_width <= EXT_W'(WIDTH_RST);
      eff_rows  <= H_W'(bmf_pkg::CONTENT_ROWS_RST + LINES);
    end else if (cfg.valid) begin
      case (bmf_pkg::cfg_reg_t'(cfg.index))
        bmf_pkg::REG_PADDED_WIDTH: eff_width <= width_next;
        bmf_pkg::REG_CONTENT_ROWS: eff_rows  <= rows_next;
        default: ;
      endcase
    end
  end

  // Position flags of the incoming pixel
  assign row_end   = (EXT_W'(col_cnt) + EXT_W'(1)) >= eff_width;
  assign frame_end = row_end && ((row_cnt + H_W'(1)) >= eff_rows);
  assign produce   = (row_cnt >= H_W'(LINES)) && (EXT_W'(col_cnt) >= EXT_W'(LINES)) &&
                     (row_cnt < eff_rows) && (EXT_W'(col_cnt) < eff_width);

  // Advance column and row counters, wrap at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_cnt <= '0;
        row_cnt <= frame_end ? '0 : row_cnt + H_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  // First stage: line store read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else if (en) begin
      tag1.valid   <= accept;
      tag1.produce <= produce;
      tag1.last    <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px1  <= pixels.pixel_in;
      col1 <= col_cnt;
    end
  end

  // Line stores: one word per column, oldest line in the low byte
  assign ram_wr = en && tag1.valid;

  bmf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (col1),
    .wr_data ({px1, ram_rd[WORD_W-1:PIX_W]}),
    .rd_en   (accept),
    .rd_addr (col_cnt),
    .rd_data (ram_rd)
  );

  // Sum the new window column
  always_comb begin
    colsum = CS_W'(px1);
    for (int k = 0; k < LINES; k++) begin
      colsum = colsum + CS_W'(ram_rd[k*PIX_W +: PIX_W]);
    end
  end

  bmf_window #(
    .RADIUS (RADIUS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_colsum (colsum),
    .in_tag    (tag1),
    .out_mean  (w_mean),
    .out_tag   (w_tag)
  );

  // Output register, drop requests that give no result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= w_tag.valid && w_tag.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mean_q <= w_mean;
      last_q <= w_tag.last;
    end
  end

  assign means.valid      = out_valid;
  assign means.mean_out   = mean_q;
  assign means.frame_last = last_q;

  // Counters restart after the last pixel of a frame
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> row_cnt == '0 && col_cnt == '0)
    else $error("counters did not wrap at frame end");

  // Write-back never hits the column read in the same cycle
  a_ram_hazard: assert property (@(posedge clk) disable iff (rst)
    ram_wr && accept |-> col1 != col_cnt)
    else $error("line store read and write collide");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    eff_width >= EXT_W'(WIN) && eff_width <= EXT_W'(MAX_WIDTH))
    else $error("effective width out of range");

  a_rows_range: assert property (@(posedge clk) disable iff (rst)
    eff_rows >= H_W'(LINES + 1) && eff_rows <= H_W'(bmf_pkg::ROWS_MAX + LINES))
    else $error("effective row count out of range");

endmodule

@@ sim/box_mean_filter_5x5_check.sv @@
module box_mean_filter_5x5_check #(
  parameter int MAX_WIDTH = 2048,
  parameter int RADIUS    = 2
) (
  input  logic  clk,
  input  logic  rst,
  bmf_cfg_if    cfg,
  bmf_pixel_if  pixels,
  bmf_mean_if   means,
  output int    fail_count,
  output int    outstanding,
  output int    pixels_seen,
  output int    means_seen,
  output int    frames_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN          = 2 * RADIUS + 1;
  localparam int LINES        = 2 * RADIUS;
  localparam int REPORT_LIMIT = 10;
  localparam int PIX_W        = bmf_pkg::PIX_W;
  localparam int CFG_W        = bmf_pkg::CFG_W;
  localparam int ROWS_MAX     = bmf_pkg::ROWS_MAX;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic             last;
  } mean_t;

  // Shadow copy of the filter state
  logic [PIX_W-1:0] lines [LINES][MAX_WIDTH];
  logic [PIX_W-1:0] win [WIN][WIN];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] rows_reg;
  int               col_cnt;
  int               row_cnt;
  mean_t            mean_queue [$];

  // Count a failure, print only the first few
  task automatic note_error(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    int               w;
    int               h;
    int               c;
    int               sum;
    bit               row_end;
    bit               frame_end;
    logic [PIX_W-1:0] column [WIN];
    mean_t            want;

    if (rst) begin
      width_reg = bmf_pkg::PADDED_WIDTH_RST;
      rows_reg  = bmf_pkg::CONTENT_ROWS_RST;
      col_cnt   = 0;
      row_cnt   = 0;
      foreach (lines[k, m]) lines[k][m] = '0;
      foreach (win[k, m]) win[k][m] = '0;
      mean_queue.delete();
    end else begin
      // Track register writes
      if (cfg.valid && cfg.ready) begin
        case (bmf_pkg::cfg_reg_t'(cfg.index))
          bmf_pkg::REG_PADDED_WIDTH: width_reg = cfg.data;
          bmf_pkg::REG_CONTENT_ROWS: rows_reg = cfg.data;
          default: ;
        endcase
      end

      // Advance the shadow window and predict the mean for this pixel
      if (pixels.valid && pixels.ready) begin
        pixels_seen++;
        w = int'(width_reg);
        if (w < WIN) w = WIN;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = int'(rows_reg);
        if (h < 1) h = 1;
        if (h > ROWS_MAX) h = ROWS_MAX;
        h = h + LINES;
        c = col_cnt;
        if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;

        // Oldest line first, newest pixel last
        for (int k = 0; k < LINES; k++) column[k] = lines[k][c];
        column[LINES] = pixels.pixel_in;
        for (int k = 0; k + 1 < LINES; k++) lines[k][c] = lines[k + 1][c];
        lines[LINES - 1][c] = pixels.pixel_in;

        for (int k = 0; k < WIN; k++) begin
          for (int m = 0; m + 1 < WIN; m++) win[k][m] = win[k][m + 1];
          win[k][WIN - 1] = column[k];
        end

        row_end   = (c + 1 >= w);
        frame_end = row_end && (row_cnt + 1 >= h);

        if (row_cnt >= LINES && c >= LINES && row_cnt < h && c < w) begin
          sum = 0;
          foreach (win[k, m]) sum += int'(win[k][m]);
          want.mean = PIX_W'(sum / (WIN * WIN));
          want.last = frame_end;
          mean_queue.push_back(want);
        end

        if (row_end) begin
          col_cnt = 0;
          row_cnt = frame_end ? 0 : row_cnt + 1;
        end else begin
          col_cnt = c + 1;
        end
      end

      // Compare each accepted mean against the oldest prediction
      if (means.valid && means.ready) begin
        means_seen++;
        if (means.frame_last === 1'b1) frames_seen++;
        if (mean_queue.size() == 0) begin
          note_error($sformatf("mean %0h (last %0b) arrived with no pixel pending",
                               means.mean_out, means.frame_last));
        end else begin
          want = mean_queue.pop_front();
          if (means.mean_out !== want.mean) begin
            note_error($sformatf("mean_out expected %0h, got %0h", want.mean, means.mean_out));
          end
          if (means.frame_last !== want.last) begin
            note_error($sformatf("frame_last expected %0b, got %0b",
                                 want.last, means.frame_last));
          end
        end
      end
    end
    outstanding <= mean_queue.size();
  end

endmodule

@@ sim/box_mean_filter_5x5_test.sv @@
module box_mean_filter_5x5_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH     = 2048;
  localparam int RADIUS        = 2;
  localparam int MIN_WIDTH     = 2 * RADIUS + 1;
  localparam int PIX_W         = bmf_pkg::PIX_W;
  localparam int CFG_W         = bmf_pkg::CFG_W;
  localparam int ROWS_MAX      = bmf_pkg::ROWS_MAX;
  localparam int RANDOM_PIXELS = 800;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 16;

  typedef enum int {
    FRAME_BORDERED,
    FRAME_PEAK,
    FRAME_NOISE,
    FRAME_ANY
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int hold_asks    = 0;
  bit steady       = 1'b0;
  int pixels_sent  = 0;
  int settings_run = 0;

  int fail_count;
  int outstanding;
  int pixels_seen;
  int means_seen;
  int frames_seen;

  always #5 clk = ~clk;

  bmf_cfg_if   cfg_if ();
  bmf_pixel_if pix_if ();
  bmf_mean_if  mean_if ();

  box_mean_filter_5x5 #(
    .MAX_WIDTH (MAX_WIDTH),
    .RADIUS    (RADIUS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .pixels (pix_if),
    .means  (mean_if)
  );

  box_mean_filter_5x5_check #(
    .MAX_WIDTH (MAX_WIDTH),
    .RADIUS    (RADIUS)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_if),
    .pixels      (pix_if),
    .means       (mean_if),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .pixels_seen (pixels_seen),
    .means_seen  (means_seen),
    .frames_seen (frames_seen)
  );

  // Gap before a pixel request: mostly none, a few long
  function automatic int pick_gap();
    int n;
    if (steady) return 0;
    n = $urandom_range(0, 99);
    if (n < 65) return 0;
    if (n < 90) return $urandom_range(1, 3);
    if (n < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one pixel and hold it until accepted
  task automatic push_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= px;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Write one register; the caller drops valid after the last write
  task automatic write_reg(input bmf_pkg::cfg_reg_t idx, input int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_W'(value);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Wait for every predicted mean, then let the pipeline drain
  task automatic settle();
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send one whole bordered frame in raster order
  task automatic send_frame(input int w, input int rows, input frame_kind_t kind);
    frame_kind_t      k;
    bit               on_border;
    logic [PIX_W-1:0] px;
    int               n;
    k = kind;
    if (k == FRAME_ANY) begin
      n = $urandom_range(0, 9);
      k = (n < 7) ? FRAME_BORDERED : (n == 7) ? FRAME_PEAK : FRAME_NOISE;
    end
    for (int r = 0; r < rows + 2 * RADIUS; r++) begin
      for (int c = 0; c < w; c++) begin
        on_border = (r < RADIUS) || (r >= rows + RADIUS) || (c < RADIUS) || (c >= w - RADIUS);
        case (k)
          FRAME_PEAK:  px = '1;
          FRAME_NOISE: px = PIX_W'($urandom_range(0, 255));
          default:     px = on_border ? '0 : PIX_W'($urandom_range(0, 255));
        endcase
        push_pixel(px);
      end
    end
  endtask

  // Reprogram the frame size while idle, then stream whole frames
  task automatic run_phase(input int wv, input int rv, input int frames,
                           input frame_kind_t kind, input bit squeeze);
    int w;
    int rows;
    w    = (wv < MIN_WIDTH) ? MIN_WIDTH : (wv > MAX_WIDTH) ? MAX_WIDTH : wv;
    rows = (rv < 1) ? 1 : (rv > ROWS_MAX) ? ROWS_MAX : rv;
    settle();
    if ($urandom_range(0, 1)) begin
      write_reg(bmf_pkg::REG_PADDED_WIDTH, wv);
      write_reg(bmf_pkg::REG_CONTENT_ROWS, rv);
    end else begin
      write_reg(bmf_pkg::REG_CONTENT_ROWS, rv);
      write_reg(bmf_pkg::REG_PADDED_WIDTH, wv);
    end
    cfg_if.valid <= 1'b0;
    if (squeeze) hold_asks <= hold_asks + 1;
    settings_run++;
    repeat (frames) send_frame(w, rows, kind);
    pix_if.valid <= 1'b0;
  endtask

  // Receiver: random ready stretches, plus one long hold on request
  initial begin
    int run;
    int served;
    int n;
    run    = 0;
    served = 0;
    mean_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != served) begin
        served = hold_asks;
        mean_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        run = 0;
      end else if (run == 0) begin
        n = $urandom_range(0, 99);
        if (n < 5) begin
          mean_if.ready <= 1'b1;
          run = $urandom_range(100, 300);
        end else if (n < 60) begin
          mean_if.ready <= 1'b1;
          run = $urandom_range(1, 30);
        end else if (n < 90) begin
          mean_if.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else if (n < 97) begin
          mean_if.ready <= 1'b0;
          run = $urandom_range(4, 12);
        end else begin
          mean_if.ready <= 1'b0;
          run = $urandom_range(20, 60);
        end
      end
      if (run > 0) run--;
    end
  end

  // Watchdog: abort when no request moves for too long
  initial begin
    int idle;
    idle = 0;
    @(negedge rst);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((pix_if.valid && pix_if.ready) || (mean_if.valid && mean_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("No request accepted for %0d cycles, giving up", IDLE_LIMIT);
    $display("box_mean_filter_5x5 verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    int base;
    int wv;
    int rv;
    int n;
    pix_if.valid    <= 1'b0;
    pix_if.pixel_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= bmf_pkg::REG_PADDED_WIDTH;
    cfg_if.data     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Smallest frame from zero register values, every pixel at full scale
    run_phase(0, 0, 1, FRAME_PEAK, 1'b0);

    // Back up the output for a long stretch while pixels keep coming
    steady = 1'b1;
    run_phase(16, 10, 2, FRAME_BORDERED, 1'b1);

    // Random frame sizes, mostly small, now and then out of range
    steady = 1'b0;
    base = pixels_sent;
    while (pixels_sent - base < RANDOM_PIXELS) begin
      n  = $urandom_range(0, 9);
      wv = (n < 8) ? $urandom_range(5, 24) : (n == 8) ? $urandom_range(0, 4)
                                                       : $urandom_range(25, 80);
      n  = $urandom_range(0, 9);
      rv = (n < 8) ? $urandom_range(1, 6) : (n == 8) ? 0 : $urandom_range(7, 12);
      steady = ($urandom_range(0, 3) == 0);
      run_phase(wv, rv, $urandom_range(1, 3), FRAME_ANY, 1'b0);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Streamed %0d pixels over %0d frame sizes, undersized register values included",
             pixels_seen, settings_run);
    $display("Checked %0d means and %0d frame ends under random and long output stalls",
             means_seen, frames_seen);
    if (fail_count == 0) begin
      $display("box_mean_filter_5x5 verification clean");
    end else begin
      $display("box_mean_filter_5x5 verification failed");
    end
    $finish;
  end

endmodule
